FILE: rtl/core/lfpa_pkg.sv
// ============================================================================
// lfpa_pkg: shared types and constants of the LED frame playback addresser
// Field widths, register indexes, reset values and the structs that travel
// between the front end, the command queue and the back end.
// ============================================================================
package lfpa_pkg;

    // Field widths.
    localparam int ADDR_W     = 25;
    localparam int PIX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int FRAME_W    = 16;
    localparam int TIME_W     = 32;
    localparam int BASE_W     = 24;
    localparam int LEN_W      = 24;
    localparam int FPS_W      = 8;
    localparam int DEN_W      = 18;
    localparam int OFF_W      = 8;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Command queue geometry.
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = 1;
    localparam int CMD_CNT_W  = 2;

    // Milliseconds in one second.
    localparam int MS_PER_S   = 1000;

    // Input opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SYNC = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FPS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP   = 3'd5;

    // Configuration reset values.
    localparam logic              RST_PRESENT = 1'b0;
    localparam logic [BASE_W-1:0] RST_BASE    = 24'd768;
    localparam logic [LEN_W-1:0]  RST_LENGTH  = 24'd150;
    localparam logic [FRAME_W-1:0] RST_FRAMES = 16'd50;
    localparam logic [FPS_W-1:0]  RST_FPS     = 8'd10;
    localparam logic [CNT_W-1:0]  RST_STRIP   = 7'd50;

    // Configuration register file contents.
    typedef struct packed {
        logic               present;
        logic [BASE_W-1:0]  base;
        logic [LEN_W-1:0]   length;
        logic [FRAME_W-1:0] frames;
        logic [FPS_W-1:0]   fps;
        logic [CNT_W-1:0]   strip;
    } cfg_t;

    // One frame command from the front end to the back end.
    typedef struct packed {
        logic               blank_all;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

    // Command queue status.
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [CMD_CNT_W-1:0] count;
    } fifo_stat_t;

endpackage

FILE: rtl/core/lfpa_if.sv
// ============================================================================
// lfpa_if: item and result channels of the LED frame playback addresser
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================

// Input item channel.
interface lfpa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [lfpa_pkg::TIME_W-1:0]  now_ms;
    logic [lfpa_pkg::FRAME_W-1:0] sync_frame;

    modport source (output valid, output opcode, output now_ms, output sync_frame,
                    input ready);
    modport sink   (input valid, input opcode, input now_ms, input sync_frame,
                    output ready);
endinterface

// Result channel.
interface lfpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [lfpa_pkg::PIX_W-1:0]  pixel_index;
    logic [lfpa_pkg::ADDR_W-1:0] source_address;
    logic                        blank;
    logic                        last;

    modport source (output valid, output pixel_index, output source_address,
                    output blank, output last, input ready);
    modport sink   (input valid, input pixel_index, input source_address,
                    input blank, input last, output ready);
endinterface

FILE: rtl/core/led_frame_playback_addresser.sv
// Plays an LED animation stored in flash by giving, for every LED of a due
// frame, the flash byte address of its red byte. A sync item or a tick that is
// not due yields nothing. A tick with no pattern present yields one blank
// result per LED, one per cycle while the output is taken; its command passes
// through the command queue and the sequencer before the output register is
// loaded. For a due frame the back end pops the command, finds the frame width
// with a restoring divider, then does the multiply and the add, and loads the
// output register with the first result. It then gives one result per cycle
// while the output is taken. A two-entry command queue lets new ticks be
// taken while a frame is still being emitted.

// ============================================================================
// led_frame_playback_addresser: top level
// Configuration registers, front end, command queue and back end.
// ============================================================================
module led_frame_playback_addresser #(
    parameter int MAX_LEDS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lfpa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lfpa_pkg::CFG_DATA_W-1:0] wr_data,
    lfpa_in_if.sink                         item,
    lfpa_out_if.source                      result
);
    import lfpa_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic [CNT_W-1:0] n_leds;
    logic             push;
    logic             pop;
    cmd_t             cmd_in;
    cmd_t             cmd_out;
    fifo_stat_t       q_stat;

    // Configuration writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_PRESENT: cfg_next.present = wr_data[0];
                REG_BASE:    cfg_next.base    = wr_data[BASE_W-1:0];
                REG_LENGTH:  cfg_next.length  = wr_data[LEN_W-1:0];
                REG_FRAMES:  cfg_next.frames  = wr_data[FRAME_W-1:0];
                REG_FPS:     cfg_next.fps     = wr_data[FPS_W-1:0];
                REG_STRIP:   cfg_next.strip   = wr_data[CNT_W-1:0];
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.present <= RST_PRESENT;
            cfg_reg.base    <= RST_BASE;
            cfg_reg.length  <= RST_LENGTH;
            cfg_reg.frames  <= RST_FRAMES;
            cfg_reg.fps     <= RST_FPS;
            cfg_reg.strip   <= RST_STRIP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Strip lengths beyond the supported count are clamped.
    assign n_leds = (cfg_reg.strip > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg_reg.strip;

    lfpa_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item),
        .q_full (q_stat.full),
        .push   (push),
        .cmd    (cmd_in)
    );

    lfpa_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .pop     (pop),
        .rd_data (cmd_out),
        .stat    (q_stat)
    );

    lfpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .n_leds  (n_leds),
        .q_empty (q_stat.empty),
        .q_data  (cmd_out),
        .pop     (pop),
        .result  (result)
    );

    // A stalled result stays on the output unchanged until it is taken.
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid
            && $stable(result.pixel_index) && $stable(result.source_address)
            && $stable(result.blank) && $stable(result.last)))
        else $error("stalled result changed before its transfer");

    // Blank results always carry a zero address.
    a_blank_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.blank) |-> (result.source_address == '0))
        else $error("blank result with a nonzero address");

    // A sync transfer never adds a frame command.
    a_sync_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.opcode == OP_SYNC))
        |=> (q_stat.count <= $past(q_stat.count)))
        else $error("sync transfer queued a frame command");

endmodule

FILE: rtl/core/lfpa_front.sv
// ============================================================================
// lfpa_front: item intake and frame scheduling
// Takes ticks and syncs, keeps the frame number and the last frame time, and
// queues one command for every tick that produces a frame of results.
// ============================================================================
module lfpa_front (
    input  logic           clk,
    input  logic           rst_n,
    input  lfpa_pkg::cfg_t cfg,
    lfpa_in_if.sink        item,
    input  logic           q_full,
    output logic           push,
    output lfpa_pkg::cmd_t cmd
);
    import lfpa_pkg::*;

    logic [FRAME_W-1:0] cur_frame_reg, cur_frame_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;

    logic               fire;
    logic               is_tick;
    logic [TIME_W-1:0]  elapsed;
    logic [10:0]        elapsed_p1;
    logic [18:0]        scaled;
    logic               due;
    logic [FRAME_W:0]   frame_inc;

    // Accept whenever the queue has room.
    assign item.ready = !q_full;
    assign fire       = item.valid && item.ready;
    assign is_tick    = (item.opcode == OP_TICK);

    // Due test: floor(1000/fps) <= e holds exactly when (e+1)*fps > 1000.
    // Any elapsed time of a second or more is due for every nonzero rate.
    assign elapsed    = item.now_ms - last_time_reg;
    assign elapsed_p1 = {1'b0, elapsed[9:0]} + 11'd1;
    assign scaled     = 19'(elapsed_p1 * cfg.fps);
    assign due        = (cfg.fps == '0) || (elapsed >= TIME_W'(MS_PER_S))
                        || (scaled > 19'(MS_PER_S));

    // A frame command goes out for blank ticks and for due ticks.
    assign push          = fire && is_tick && (!cfg.present || due);
    assign cmd.blank_all = !cfg.present;
    assign cmd.frame     = cur_frame_reg;

    // Frame and time bookkeeping.
    assign frame_inc = {1'b0, cur_frame_reg} + 17'd1;

    always_comb
    begin
        cur_frame_next = cur_frame_reg;
        last_time_next = last_time_reg;
        if (fire)
        begin
            if (!is_tick)
            begin
                cur_frame_next = item.sync_frame;
                last_time_next = '0;
            end
            else if (cfg.present && due)
            begin
                last_time_next = item.now_ms;
                if (frame_inc >= {1'b0, cfg.frames})
                    cur_frame_next = '0;
                else
                    cur_frame_next = frame_inc[FRAME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_frame_reg <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            cur_frame_reg <= cur_frame_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

FILE: rtl/core/lfpa_cmd_fifo.sv
// ============================================================================
// lfpa_cmd_fifo: frame command queue
// A short first-in first-out queue that lets the front end run ahead of the
// back end while it emits a frame.
// ============================================================================
module lfpa_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lfpa_pkg::cmd_t       wr_data,
    input  logic                 pop,
    output lfpa_pkg::cmd_t       rd_data,
    output lfpa_pkg::fifo_stat_t stat
);
    import lfpa_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign stat.full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign rd_data    = entry_reg[rd_ptr_reg];

    assign do_wr = push && !stat.full;
    assign do_rd = pop && !stat.empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: rtl/core/lfpa_back.sv
// ============================================================================
// lfpa_back: frame address generation
// Takes one frame command at a time; for a non-blank command it works out the
// frame width with a restoring divider and the frame start with one multiply
// and one add. It then emits one result per LED through an output register.
// ============================================================================
module lfpa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfpa_pkg::cfg_t                cfg,
    input  logic [lfpa_pkg::CNT_W-1:0]    n_leds,
    input  logic                          q_empty,
    input  lfpa_pkg::cmd_t                q_data,
    output logic                          pop,
    lfpa_out_if.source                    result
);
    import lfpa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 blank_reg, blank_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [LEN_W-1:0]     dvd_reg, dvd_next;
    logic [DEN_W:0]       rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [ADDR_W-1:0]    prod_reg, prod_next;
    logic [ADDR_W-1:0]    start_reg, start_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     m_reg, m_next;
    logic [OFF_W-1:0]     off_reg, off_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     pix_reg, pix_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 oblank_reg, oblank_next;
    logic                 last_reg, last_next;

    logic [DEN_W-1:0]     den_calc;
    logic [DEN_W:0]       rem_shift;
    logic [ADDR_W-1:0]    width3;
    logic [ADDR_W+FRAME_W-1:0] prod_full;
    logic [CNT_W-1:0]     k_p1;
    logic [CNT_W-1:0]     m_p1;
    logic                 load_ok;
    logic                 final_led;

    assign result.valid          = out_valid_reg;
    assign result.pixel_index    = pix_reg;
    assign result.source_address = addr_reg;
    assign result.blank          = oblank_reg;
    assign result.last           = last_reg;

    // Datapath helpers.
    assign den_calc  = {1'b0, cfg.frames, 1'b0} + {2'b00, cfg.frames};
    assign rem_shift = {rem_reg[DEN_W-1:0], dvd_reg[LEN_W-1]};
    assign width3    = {dvd_reg, 1'b0} + {1'b0, dvd_reg};
    assign prod_full = width3 * frame_reg;
    assign k_p1      = k_reg + 1'b1;
    assign m_p1      = m_reg + 1'b1;
    assign load_ok   = !out_valid_reg || result.ready;
    assign final_led = (k_p1 == n_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        blank_next     = blank_reg;
        frame_next     = frame_reg;
        n_next         = n_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        bit_cnt_next   = bit_cnt_reg;
        prod_next      = prod_reg;
        start_next     = start_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        off_next       = off_reg;
        pix_next       = pix_reg;
        addr_next      = addr_reg;
        oblank_next    = oblank_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        // The output slot empties on a transfer.
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    frame_next   = q_data.frame;
                    n_next       = n_leds;
                    k_next       = '0;
                    m_next       = '0;
                    off_next     = '0;
                    dvd_next     = cfg.length;
                    rem_next     = '0;
                    den_next     = den_calc;
                    bit_cnt_next = '0;
                    blank_next   = q_data.blank_all;
                    state_next   = q_data.blank_all ? S_EMIT : S_DIV;
                end
            end

            // One quotient bit per cycle; the quotient replaces the dividend.
            S_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = rem_shift - {1'b0, den_reg};
                    dvd_next = {dvd_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    dvd_next = {dvd_reg[LEN_W-2:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == DIV_CNT_W'(LEN_W - 1))
                    state_next = S_MUL;
            end

            // A zero width (or no frames) blanks the whole frame.
            S_MUL:
            begin
                if ((den_reg == '0) || (dvd_reg == '0))
                begin
                    blank_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    prod_next  = prod_full[ADDR_W-1:0];
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                start_next = {1'b0, cfg.base} + prod_reg;
                state_next = S_EMIT;
            end

            // One LED per cycle while the output slot can take it.
            S_EMIT:
            begin
                if (n_reg == '0)
                    state_next = S_IDLE;
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    pix_next       = k_reg[PIX_W-1:0];
                    addr_next      = blank_reg ? '0 : start_reg + ADDR_W'(off_reg);
                    oblank_next    = blank_reg;
                    last_next      = final_led;
                    k_next         = k_p1;
                    if ({{(LEN_W-CNT_W){1'b0}}, m_p1} == dvd_reg)
                    begin
                        m_next   = '0;
                        off_next = '0;
                    end
                    else
                    begin
                        m_next   = m_p1;
                        off_next = off_reg + OFF_W'(3);
                    end
                    if (final_led)
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        blank_reg   <= blank_next;
        frame_reg   <= frame_next;
        n_reg       <= n_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        bit_cnt_reg <= bit_cnt_next;
        prod_reg    <= prod_next;
        start_reg   <= start_next;
        k_reg       <= k_next;
        m_reg       <= m_next;
        off_reg     <= off_next;
        pix_reg     <= pix_next;
        addr_reg    <= addr_next;
        oblank_reg  <= oblank_next;
        last_reg    <= last_next;
    end

endmodule
